// ===== rtl/bvg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvg_pkg
// Shared constants and types of the battery voltage gauge.
// ----------------------------------------------------------------------------
package bvg_pkg;

  localparam int RING_DEPTH = 16;

  // Register reset values
  localparam logic [23:0] GAIN_RST   = 24'd108400;
  localparam logic [13:0] OFFSET_RST = 14'd530;
  localparam logic [15:0] FULL_RST   = 16'd4200;
  localparam logic [15:0] EMPTY_RST  = 16'd3300;

  // Stored voltages strictly between zero and this limit enter the average
  localparam logic [15:0] VALID_LIMIT_MV = 16'd10000;
  localparam logic [20:0] SAT_MV         = 21'd65535;
  localparam logic [6:0]  FULL_PCT       = 7'd100;
  localparam logic [6:0]  LOW_PCT        = 7'd30;

  // Divisor width of the shared divider (window count or voltage span)
  localparam int DIVISOR_W = 16;
  // (average - empty) * 100 stays below 10000 * 100
  localparam int NUM_W     = 20;

  typedef enum logic [1:0] {
    CFG_GAIN   = 2'd0,
    CFG_OFFSET = 2'd1,
    CFG_FULL   = 2'd2,
    CFG_EMPTY  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ring_ctl_t;

endpackage

// ===== rtl/battery_voltage_gauge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_voltage_gauge
// Moving-average battery fuel gauge with charge percentage and flags.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per raw 12-bit ADC reading (in_tdata[11:0]).
//   out_* : one word per reading: average_mv, percent, is_low, is_dead.
//   cfg_* : gain, offset, full and empty voltage; write only while idle.
// Each reading is scaled to millivolts, written over the oldest ring entry,
// and the running sum and count of qualifying entries (0 < v < 10000 mV)
// are updated by read-modify-write of that entry. The average and the
// percentage then go through one shared bit-serial divider.
// The divider runs up to two passes of DIV_NW quotient bits, DIV_NW being the
// wider of SUM_W and NUM_W; an empty window skips the first pass and a
// percentage known to be zero skips the second.
// One reading is processed at a time; the next is accepted as soon as the
// result sits in the output register, even if the receiver stalls it.
// Reset clears the ring (through valid bits, no clearing pass), the write
// slot, the sum and count, and loads the register reset values.
// ----------------------------------------------------------------------------
module battery_voltage_gauge #(
  parameter int RING_DEPTH = bvg_pkg::RING_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] adc_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [13:0] average_mv, [20:14] percent,
                                  // [21] is_low, [22] is_dead
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W  = $clog2(RING_DEPTH * 9999 + 1);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int NUM_W  = bvg_pkg::NUM_W;
  localparam int DIV_NW = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int DW     = bvg_pkg::DIVISOR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_UPD, S_AVG, S_AVGW, S_PCT, S_PDIV, S_PDW, S_OUT
  } state_t;

  state_t      state_r;

  logic [23:0] gain_r;
  logic [13:0] offset_r;
  logic [15:0] full_r;
  logic [15:0] empty_r;

  logic [35:0]      prod_r;
  logic [15:0]      mv_r;
  logic [AW-1:0]    slot_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic [13:0]      avg_r;
  logic [NUM_W-1:0] num_r;
  logic [6:0]       pct_r;
  logic             out_tvalid_r;
  logic [23:0]      out_tdata_r;

  bvg_pkg::ring_ctl_t ring_ctl;
  logic [15:0]        ring_rd;

  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DW-1:0]     div_den;
  logic              div_done;
  logic [DIV_NW-1:0] div_q;

  logic [20:0] mv_wide;
  logic        old_q;
  logic        new_q;
  logic [15:0] diff_mv;

  always_comb begin
    mv_wide = {1'b0, prod_r[35:16]} + 21'(offset_r);
    old_q   = (ring_rd != 16'd0) && (ring_rd < bvg_pkg::VALID_LIMIT_MV);
    new_q   = (mv_r != 16'd0) && (mv_r < bvg_pkg::VALID_LIMIT_MV);
    diff_mv = {2'b00, avg_r} - empty_r;
  end

  assign ring_ctl.rd_en = (state_r == S_SCALE);
  assign ring_ctl.wr_en = (state_r == S_UPD);

  assign div_start = (state_r == S_PDIV) || ((state_r == S_AVG) && (cnt_r != '0));
  assign div_num   = (state_r == S_PDIV) ? DIV_NW'(num_r) : DIV_NW'(sum_r);
  assign div_den   = (state_r == S_PDIV) ? (full_r - empty_r) : DW'(cnt_r);

  bvg_ring #(
    .RING_DEPTH (RING_DEPTH),
    .AW         (AW)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ring_ctl),
    .addr    (slot_r),
    .wr_data (mv_r),
    .rd_data (ring_rd)
  );

  bvg_div #(
    .NW (DIV_NW),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= bvg_pkg::GAIN_RST;
      offset_r <= bvg_pkg::OFFSET_RST;
      full_r   <= bvg_pkg::FULL_RST;
      empty_r  <= bvg_pkg::EMPTY_RST;
    end else if (cfg_we) begin
      case (bvg_pkg::cfg_idx_t'(cfg_index))
        bvg_pkg::CFG_GAIN:   gain_r   <= cfg_wdata;
        bvg_pkg::CFG_OFFSET: offset_r <= cfg_wdata[13:0];
        bvg_pkg::CFG_FULL:   full_r   <= cfg_wdata[15:0];
        bvg_pkg::CFG_EMPTY:  empty_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_r       <= '0;
      sum_r        <= '0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // in S_OUT the output register is reloaded whenever it drains
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            prod_r  <= 36'(in_tdata[11:0]) * 36'(gain_r);
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          mv_r    <= (mv_wide > bvg_pkg::SAT_MV) ? 16'hFFFF : mv_wide[15:0];
          state_r <= S_UPD;
        end
        S_UPD: begin
          // drop the overwritten entry, add the new one
          sum_r <= sum_r - (old_q ? SUM_W'(ring_rd[13:0]) : '0)
                         + (new_q ? SUM_W'(mv_r[13:0]) : '0);
          cnt_r <= cnt_r - CNT_W'(old_q) + CNT_W'(new_q);
          slot_r  <= (slot_r == AW'(RING_DEPTH - 1)) ? '0 : slot_r + AW'(1);
          state_r <= S_AVG;
        end
        S_AVG: begin
          if (cnt_r == '0) begin
            avg_r   <= '0;
            state_r <= S_PCT;
          end else begin
            state_r <= S_AVGW;
          end
        end
        S_AVGW: begin
          if (div_done) begin
            avg_r   <= div_q[13:0];
            state_r <= S_PCT;
          end
        end
        S_PCT: begin
          if ((full_r <= empty_r) || ({2'b00, avg_r} <= empty_r)) begin
            pct_r   <= '0;
            state_r <= S_OUT;
          end else begin
            num_r   <= NUM_W'(diff_mv[13:0]) * NUM_W'(bvg_pkg::FULL_PCT);
            state_r <= S_PDIV;
          end
        end
        S_PDIV: begin
          state_r <= S_PDW;
        end
        S_PDW: begin
          if (div_done) begin
            pct_r   <= (div_q > DIV_NW'(bvg_pkg::FULL_PCT)) ? bvg_pkg::FULL_PCT
                                                            : div_q[6:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {1'b0, (pct_r == 7'd0), (pct_r < bvg_pkg::LOW_PCT),
                             pct_r, avg_r};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== rtl/bvg_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvg_ring
// Voltage ring memory, one write or one registered read per cycle. Entries
// never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module bvg_ring #(
  parameter int RING_DEPTH = bvg_pkg::RING_DEPTH,
  parameter int AW         = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bvg_pkg::ring_ctl_t  ctl,
  input  logic [AW-1:0]       addr,
  input  logic [15:0]         wr_data,
  output logic [15:0]         rd_data
);

  logic [15:0]           mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_r;
  logic [15:0]           rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= valid_r[addr] ? mem[addr] : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bvg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvg_div
// Restoring divider, one quotient bit per cycle, NW quotient bits per division.
// ----------------------------------------------------------------------------
module bvg_div #(
  parameter int NW = 20,
  parameter int DW = bvg_pkg::DIVISOR_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   rem_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] div_r;

  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   rem_nxt;
  logic [NW-1:0] quo_nxt;

  always_comb begin
    rem_sh  = {rem_r[DW-1:0], quo_r[NW-1]};
    ge      = (rem_sh >= {1'b0, div_r});
    rem_nxt = ge ? (rem_sh - {1'b0, div_r}) : rem_sh;
    quo_nxt = {quo_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        rem_r  <= '0;
        quo_r  <= dividend;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the battery voltage gauge. A driver feeds ADC
// readings from a backlog queue and runs a local copy of the gauge (scaling,
// ring, windowed average, percentage) on every accepted word. A monitor checks
// each result word against the oldest prediction. Directed corner cases run
// first, then randomized phases with new register settings and random idling.
// ----------------------------------------------------------------------------
module testbench;
  import bvg_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 60;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 80;

  // Members listed from the top bit down, matching out_tdata[22:0]
  typedef struct packed {
    logic        is_dead;
    logic        is_low;
    logic [6:0]  percent;
    logic [13:0] average_mv;
  } gauge_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [11:0] adc_sample
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [13:0] average_mv, [20:14] percent,
                                  // [21] is_low, [22] is_dead
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = CFG_GAIN;
  logic [23:0] cfg_wdata  = '0;

  // Local copy of the gauge registers and state
  logic [23:0] gain_q16  = GAIN_RST;
  logic [13:0] offset_mv = OFFSET_RST;
  logic [15:0] full_mv   = FULL_RST;
  logic [15:0] empty_mv  = EMPTY_RST;
  logic [15:0] mv_ring [RING_DEPTH] = '{default: '0};
  int          ring_slot = 0;

  logic [11:0]   adc_backlog[$];
  gauge_result_t expected_readings[$];

  int idle_pct     = 20;
  bit hold_armed   = 1'b0;
  bit hold_done    = 1'b0;
  int in_gap       = 0;
  int out_gap      = 0;
  int out_hold     = 0;
  int quiet_cycles = 0;
  int fail_count   = 0;

  always #2 clk = ~clk;

  battery_voltage_gauge i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  function automatic logic [15:0] scale_to_mv(logic [11:0] reading);
    longint mv;
    mv = ((longint'(reading) * longint'(gain_q16)) >> 16) + longint'(offset_mv);
    return (mv > longint'(SAT_MV)) ? SAT_MV[15:0] : mv[15:0];
  endfunction

  function automatic gauge_result_t update_gauge(logic [11:0] reading);
    gauge_result_t res;
    logic [19:0]   sum;
    int            count;
    longint        pct;
    sum   = '0;
    count = 0;
    pct   = 0;
    mv_ring[ring_slot] = scale_to_mv(reading);
    ring_slot = (ring_slot + 1) % RING_DEPTH;
    foreach (mv_ring[i]) begin
      if (mv_ring[i] != '0 && mv_ring[i] < VALID_LIMIT_MV) begin
        sum   = sum + mv_ring[i];
        count = count + 1;
      end
    end
    res.average_mv = (count > 0) ? 14'(sum / 20'(count)) : '0;
    if (full_mv > empty_mv) begin
      // Signed division truncates toward zero; clamp afterwards
      pct = ((longint'(res.average_mv) - longint'(empty_mv)) * 100) /
            (longint'(full_mv) - longint'(empty_mv));
      if (pct < 0) pct = 0;
      if (pct > longint'(FULL_PCT)) pct = longint'(FULL_PCT);
    end
    res.percent = pct[6:0];
    res.is_low  = pct < longint'(LOW_PCT);
    res.is_dead = pct == 0;
    return res;
  endfunction

  // Driver: offer backlog words, predict on every accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_readings.push_back(update_gauge(in_tdata[11:0]));
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (adc_backlog.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if ($urandom_range(1, 100) <= idle_pct) begin
          in_gap    <= $urandom_range(0, 11);
          in_tvalid <= 1'b0;
        end else begin
          in_tdata  <= {4'd0, adc_backlog.pop_front()};
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // Monitor: check result words, drive out_tready
  always @(posedge clk) begin
    gauge_result_t got;
    gauge_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[22:0];
        if (expected_readings.size() == 0) begin
          $error("result word with nothing expected: %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          if (got.average_mv !== want.average_mv) begin
            $error("average_mv: expected %0d, got %0d", want.average_mv, got.average_mv);
            fail_count++;
          end
          if (got.percent !== want.percent) begin
            $error("percent: expected %0d, got %0d", want.percent, got.percent);
            fail_count++;
          end
          if (got.is_low !== want.is_low) begin
            $error("is_low: expected %0d, got %0d", want.is_low, got.is_low);
            fail_count++;
          end
          if (got.is_dead !== want.is_dead) begin
            $error("is_dead: expected %0d, got %0d", want.is_dead, got.is_dead);
            fail_count++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold   <= out_hold - 1;
        out_tready <= 1'b0;
      end else if (hold_armed && !hold_done && adc_backlog.size() > 20) begin
        // Long hold while the sender keeps offering: fills the block
        hold_done  <= 1'b1;
        out_hold   <= LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else if ($urandom_range(1, 100) <= idle_pct) begin
        out_gap    <= $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("battery_voltage_gauge test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_GAIN:   gain_q16  = value;
      CFG_OFFSET: offset_mv = value[13:0];
      CFG_FULL:   full_mv   = value[15:0];
      CFG_EMPTY:  empty_mv  = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_gauge(input logic [23:0] gain, input logic [13:0] offset,
                           input logic [15:0] full, input logic [15:0] empty);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_OFFSET, 24'(offset));
    write_reg(CFG_FULL, 24'(full));
    write_reg(CFG_EMPTY, 24'(empty));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sample at the falling edge so the posedge updates have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (adc_backlog.size() != 0 || in_tvalid || expected_readings.size() != 0);
  endtask

  initial begin
    int          center;
    int          lo;
    int          hi;
    int          jit;
    logic [23:0] gain;
    logic [13:0] offset;
    logic [15:0] full;
    logic [15:0] empty;
    logic [15:0] mv_c;
    logic [11:0] reading;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty window: every reading scales to 0 mV
    set_gauge(24'd0, 14'd0, FULL_RST, EMPTY_RST);
    adc_backlog.push_back(12'd0);
    adc_backlog.push_back(12'd4095);
    wait_idle();

    // Saturation and the upper limit: nothing qualifies, window stays empty
    set_gauge(24'hFFFFFF, 14'd10000, 16'hFFFF, 16'd0);
    adc_backlog.push_back(12'd4095);
    adc_backlog.push_back(12'd1);
    adc_backlog.push_back(12'd0);
    wait_idle();

    // Just inside the window at both ends
    set_gauge(24'd0, 14'd9999, 16'hFFFF, 16'd0);
    adc_backlog.push_back(12'd2222);
    wait_idle();
    set_gauge(24'd0, 14'd1, 16'hFFFF, 16'd0);
    adc_backlog.push_back(12'd3333);
    wait_idle();

    // Default calibration across the range and near empty and full
    set_gauge(GAIN_RST, OFFSET_RST, FULL_RST, EMPTY_RST);
    adc_backlog.push_back(12'd0);
    adc_backlog.push_back(12'd4095);
    adc_backlog.push_back(12'd1);
    adc_backlog.push_back(12'd2048);
    adc_backlog.push_back(12'hAAA);
    adc_backlog.push_back(12'h555);
    adc_backlog.push_back(12'd1675);
    adc_backlog.push_back(12'd2219);
    adc_backlog.push_back(12'd1900);
    wait_idle();

    // Inverted range: equal, then full below empty
    set_gauge(GAIN_RST, OFFSET_RST, 16'd3300, 16'd3300);
    adc_backlog.push_back(12'd2000);
    wait_idle();
    set_gauge(GAIN_RST, OFFSET_RST, 16'd0, 16'hFFFF);
    adc_backlog.push_back(12'd2000);
    wait_idle();

    // Above full: clamp at one hundred percent
    set_gauge(GAIN_RST, OFFSET_RST, 16'd1000, 16'd0);
    adc_backlog.push_back(12'd3000);
    adc_backlog.push_back(12'd4095);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_pct   = (p == RANDOM_PHASES - 1 || $urandom_range(0, 3) == 0) ? 0 :
                   $urandom_range(10, 40);
      hold_armed = (p == 2);
      gain   = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(16000, 400000));
      offset = 14'($urandom_range(0, 10000));
      set_gauge(gain, offset, full_mv, empty_mv);

      // Center the percentage range on the typical voltage of this phase
      center = $urandom_range(0, 4095);
      mv_c   = scale_to_mv(12'(center));
      if ($urandom_range(0, 7) == 0) begin
        full  = 16'($urandom);
        empty = 16'($urandom);
      end else begin
        lo    = int'(mv_c) - int'($urandom_range(0, 2000));
        hi    = int'(mv_c) + int'($urandom_range(1, 2000));
        empty = 16'((lo < 0) ? 0 : lo);
        full  = 16'((hi > 65535) ? 65535 : hi);
      end
      set_gauge(gain_q16, offset_mv, full, empty);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          reading = 12'($urandom_range(0, 4095));
        end else begin
          jit = center + int'($urandom_range(0, 128)) - 64;
          if (jit < 0) jit = 0;
          if (jit > 4095) jit = 4095;
          reading = 12'(jit);
        end
        adc_backlog.push_back(reading);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_readings.size() == 0) begin
      $display("battery_voltage_gauge test passed");
    end else begin
      if (expected_readings.size() != 0) begin
        $error("%0d results never arrived", expected_readings.size());
      end
      $display("battery_voltage_gauge test failed");
    end
    $finish;
  end

endmodule
